// File: sv/mwss_pkg.sv
`default_nettype none

package mwss_pkg;

  localparam int QUERY_DEPTH = 16;
  localparam int TEXT_LIMIT  = 65536;
  localparam int VALUE_WIDTH = 32;

  localparam int OP_W   = 2;
  localparam int WIN_W  = 16;
  localparam int QCNT_W = $clog2(QUERY_DEPTH + 1);
  localparam int QIDX_W = (QUERY_DEPTH > 1) ? $clog2(QUERY_DEPTH) : 1;
  localparam int POS_W  = (TEXT_LIMIT > 1) ? $clog2(TEXT_LIMIT) : 1;
  localparam int TPOS_W = $clog2(TEXT_LIMIT + 1);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_REPORT = 2'd3
  } mwss_op_e;

  typedef struct packed {
    logic clear;
    logic restart;
    logic append;
    logic text;
  } mwss_ctrl_t;

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] start;
  } mwss_hit_t;

  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] first;
    logic [POS_W-1:0] last;
    logic [POS_W-1:0] span;
  } mwss_best_t;

endpackage

`default_nettype wire

// File: sv/mwss_cells.sv
`default_nettype none

module mwss_cells (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  mwss_pkg::mwss_ctrl_t                  ctrl_i,
  input  logic [mwss_pkg::VALUE_WIDTH-1:0]      value_i,
  input  logic [mwss_pkg::POS_W-1:0]            pos_i,
  output mwss_pkg::mwss_hit_t                   hit_o,
  output logic                                  full_o
);
  import mwss_pkg::*;

  logic [VALUE_WIDTH-1:0] store_q [QUERY_DEPTH];
  logic [QCNT_W-1:0]      count_q, count_d;
  logic [QUERY_DEPTH-1:0] valid_q, valid_d;
  logic [POS_W-1:0]       start_q [QUERY_DEPTH];
  logic [QUERY_DEPTH-1:0] match;
  logic [POS_W-1:0]       start_new [QUERY_DEPTH];
  logic [QCNT_W-1:0]      count_m1;
  logic [QIDX_W-1:0]      last_idx;

  assign full_o   = (count_q == QCNT_W'(QUERY_DEPTH));
  assign count_m1 = count_q - QCNT_W'(1);
  assign last_idx = count_m1[QIDX_W-1:0];

  // each cell looks at its left neighbor as it stood before this element
  always_comb begin
    for (int j = 0; j < QUERY_DEPTH; j++) begin
      if (j == 0) begin
        match[j]     = (QCNT_W'(j) < count_q) && (store_q[j] == value_i);
        start_new[j] = pos_i;
      end else begin
        match[j]     = (QCNT_W'(j) < count_q) && (store_q[j] == value_i) && valid_q[j-1];
        start_new[j] = start_q[j-1];
      end
    end
  end

  assign hit_o.hit   = ctrl_i.text && (count_q != '0) && match[last_idx];
  assign hit_o.start = start_new[last_idx];

  always_comb begin
    count_d = count_q;
    valid_d = valid_q;
    if (ctrl_i.clear) begin
      count_d = '0;
    end else if (ctrl_i.append) begin
      count_d = count_q + QCNT_W'(1);
    end
    if (ctrl_i.restart) begin
      valid_d = '0;
    end else if (ctrl_i.text) begin
      valid_d = valid_q | match;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= '0;
    end else begin
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.append) begin
      store_q[count_q[QIDX_W-1:0]] <= value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < QUERY_DEPTH; j++) begin
      if (ctrl_i.text && match[j]) begin
        start_q[j] <= start_new[j];
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/mwss_best.sv
`default_nettype none

module mwss_best (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mwss_pkg::mwss_ctrl_t        ctrl_i,
  input  mwss_pkg::mwss_hit_t         hit_i,
  input  logic [mwss_pkg::POS_W-1:0]  pos_i,
  output mwss_pkg::mwss_best_t        best_o
);
  import mwss_pkg::*;

  logic             valid_q, valid_d;
  logic [POS_W-1:0] first_q, last_q, span_q;
  logic [POS_W-1:0] span_new;
  logic             take;

  assign span_new = pos_i - hit_i.start;
  assign take     = hit_i.hit && (!valid_q || (span_new < span_q));

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.restart) begin
      valid_d = 1'b0;
    end else if (take) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      first_q <= hit_i.start;
      last_q  <= pos_i;
      span_q  <= span_new;
    end
  end

  assign best_o.valid = valid_q;
  assign best_o.first = first_q;
  assign best_o.last  = last_q;
  assign best_o.span  = span_q;

endmodule

`default_nettype wire

// File: sv/min_window_subsequence_search_core.sv
// channel   direction  handshake               payload
// request   in         in_valid_i / in_stall_o  op_i, value_i
// result    out        out_valid_o / out_stall_i found_o, win_start_o, win_end_o,
//                                              win_width_o, overflow_o
//
// one request per cycle sustained while in_stall_o is low; a request passes an
// input register, and a report then writes its result into the result register
// all query cells update in parallel from their previous-cycle contents
// reset clears counts, match flags, best window and overflow at once
// in_stall_o rises only while a report waits for a held result register
`default_nettype none

module min_window_subsequence_search_core (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic [mwss_pkg::OP_W-1:0]                op_i,
  input  logic signed [mwss_pkg::VALUE_WIDTH-1:0]  value_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic                                     found_o,
  output logic [mwss_pkg::WIN_W-1:0]               win_start_o,
  output logic [mwss_pkg::WIN_W-1:0]               win_end_o,
  output logic [mwss_pkg::WIN_W-1:0]               win_width_o,
  output logic                                     overflow_o
);
  import mwss_pkg::*;

  logic                   s1_valid_q, s1_valid_d;
  mwss_op_e               op_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic                   in_acc, out_free, proc;

  logic [TPOS_W-1:0]      tpos_q, tpos_d;
  logic                   text_full, query_full;
  logic                   ovf_q, ovf_d;
  mwss_ctrl_t             ctrl;
  mwss_hit_t              hit;
  mwss_best_t             best;
  logic                   is_report;

  logic                   out_valid_q, out_valid_d;
  logic                   found_q, ovf_out_q;
  logic [WIN_W-1:0]       start_q, end_q, width_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc       = s1_valid_q && ((op_q != OP_REPORT) || out_free);
  assign in_stall_o = s1_valid_q && !proc;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (proc) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= mwss_op_e'(op_i);
      value_q <= value_i;
    end
  end

  assign text_full = (tpos_q >= TPOS_W'(TEXT_LIMIT));

  always_comb begin
    ctrl      = '0;
    is_report = 1'b0;
    if (proc) begin
      unique case (op_q)
        OP_CLEAR: begin
          ctrl.clear   = 1'b1;
          ctrl.restart = 1'b1;
        end
        OP_APPEND: begin
          ctrl.append  = !query_full;
          ctrl.restart = !query_full;
        end
        OP_TEXT: begin
          ctrl.text = !text_full;
        end
        OP_REPORT: begin
          is_report = 1'b1;
        end
        default: begin
          ctrl = '0;
        end
      endcase
    end
  end

  always_comb begin
    tpos_d = tpos_q;
    ovf_d  = ovf_q;
    if (ctrl.restart) begin
      tpos_d = '0;
    end else if (ctrl.text) begin
      tpos_d = tpos_q + TPOS_W'(1);
    end
    if (ctrl.clear) begin
      ovf_d = 1'b0;
    end else if (proc && (((op_q == OP_APPEND) && query_full) ||
                          ((op_q == OP_TEXT) && text_full))) begin
      ovf_d = 1'b1;
    end
  end

  mwss_cells u_cells (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .value_i (value_q),
    .pos_i   (tpos_q[POS_W-1:0]),
    .hit_o   (hit),
    .full_o  (query_full)
  );

  mwss_best u_best (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .hit_i  (hit),
    .pos_i  (tpos_q[POS_W-1:0]),
    .best_o (best)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (is_report) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      tpos_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      tpos_q      <= tpos_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_report) begin
      found_q   <= best.valid;
      ovf_out_q <= ovf_q;
      start_q   <= best.valid ? WIN_W'(best.first) : '0;
      end_q     <= best.valid ? WIN_W'(best.last) : '0;
      width_q   <= best.valid ? WIN_W'(best.span) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign win_start_o = start_q;
  assign win_end_o   = end_q;
  assign win_width_o = width_q;
  assign overflow_o  = ovf_out_q;

endmodule

`default_nettype wire

// File: sv/mwss_checker.sv
`default_nettype none

module mwss_checker (
  input logic                                     clk_i,
  input logic                                     rst_ni,
  input logic                                     in_valid_i,
  input logic                                     in_stall_o,
  input logic [mwss_pkg::OP_W-1:0]                op_i,
  input logic signed [mwss_pkg::VALUE_WIDTH-1:0]  value_i,
  input logic                                     out_valid_o,
  input logic                                     out_stall_i,
  input logic                                     found_o,
  input logic [mwss_pkg::WIN_W-1:0]               win_start_o,
  input logic [mwss_pkg::WIN_W-1:0]               win_end_o,
  input logic [mwss_pkg::WIN_W-1:0]               win_width_o,
  input logic                                     overflow_o
);

  a_request_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(op_i) && $stable(value_i))
    else $error("request changed while stalled");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(found_o) &&
      $stable(win_start_o) && $stable(win_end_o) && $stable(win_width_o) &&
      $stable(overflow_o))
    else $error("result changed while stalled");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("request stalled without a held result");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> (win_start_o == '0) && (win_end_o == '0) &&
      (win_width_o == '0))
    else $error("window fields nonzero with no window");

  a_width_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> win_width_o == (win_end_o - win_start_o))
    else $error("window width inconsistent");

endmodule

bind min_window_subsequence_search_core mwss_checker u_mwss_checker (.*);

`default_nettype wire
